// File: sv/tmsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_pkg
// shared types, codes and constants of the terrain map stream parser
// ----------------------------------------------------------------------------
package tmsp_pkg;

  localparam int MAX_TILE_COUNT_DEF = 1024;
  localparam int MAX_MAP_SIDE_DEF   = 16384;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_GTILE  = 3'd1;
  localparam logic [2:0] KIND_CTILE  = 3'd2;
  localparam logic [2:0] KIND_CORNER = 3'd3;
  localparam logic [2:0] KIND_STAT   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SHORT    = 4'd1;
  localparam logic [3:0] ST_BADSIG   = 4'd2;
  localparam logic [3:0] ST_BADGCNT  = 4'd3;
  localparam logic [3:0] ST_BADCCNT  = 4'd4;
  localparam logic [3:0] ST_BADSIZE  = 4'd5;
  localparam logic [3:0] ST_TRHDR    = 4'd6;
  localparam logic [3:0] ST_TRTILE   = 4'd7;
  localparam logic [3:0] ST_TRCORNER = 4'd8;

  localparam logic [3:0] LAST_STAT = 4'd8;

  typedef struct packed {
    logic        has_word;
    logic [2:0]  word_kind;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        has_corner;
    logic        corner_final;
    logic [15:0] raw_height;
    logic [13:0] water_raw;
    logic [5:0]  ground_texture;
    logic [4:0]  corner_flags;
    logic [4:0]  ground_variation;
    logic [2:0]  cliff_variation;
    logic [3:0]  cliff_texture;
    logic [3:0]  layer_height;
    logic        has_status;
    logic [3:0]  status_code;
  } cmd_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h57;
      2'd1:    r = 8'h33;
      2'd2:    r = 8'h45;
      default: r = 8'h21;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tmsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_front
// byte parser: signature, header, tile lists and corner record unpacking
// ----------------------------------------------------------------------------
module tmsp_front #(
  parameter int MAX_TILE_COUNT = tmsp_pkg::MAX_TILE_COUNT_DEF,
  parameter int MAX_MAP_SIDE   = tmsp_pkg::MAX_MAP_SIDE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           end_of_file,
  output logic           push,
  output tmsp_pkg::cmd_t cmd
);

  localparam int TW = $clog2(MAX_TILE_COUNT + 1);
  localparam int SW = $clog2(MAX_MAP_SIDE + 1);
  localparam int CW = 2 * SW;

  localparam logic [3:0] PH_SIG     = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_TILESET = 4'd2;
  localparam logic [3:0] PH_CUSTOM  = 4'd3;
  localparam logic [3:0] PH_GCOUNT  = 4'd4;
  localparam logic [3:0] PH_GTILES  = 4'd5;
  localparam logic [3:0] PH_CCOUNT  = 4'd6;
  localparam logic [3:0] PH_CTILES  = 4'd7;
  localparam logic [3:0] PH_WIDTH   = 4'd8;
  localparam logic [3:0] PH_HEIGHT  = 4'd9;
  localparam logic [3:0] PH_OFFX    = 4'd10;
  localparam logic [3:0] PH_OFFY    = 4'd11;
  localparam logic [3:0] PH_CORNERS = 4'd12;
  localparam logic [3:0] PH_DONE    = 4'd13;

  logic [3:0]    phase, phase_next;
  logic [2:0]    bif, bif_next;
  logic [63:0]   field_shift, field_shift_next;
  logic [31:0]   version, version_next;
  logic [TW-1:0] tiles_left, tiles_left_next;
  logic [SW-1:0] map_width, map_width_next;
  logic [SW-1:0] map_height, map_height_next;
  logic          width_bad, width_bad_next;
  logic          height_bad, height_bad_next;
  logic [CW-1:0] corners_left, corners_left_next;
  logic [5:0]    bytes_seen, bytes_seen_next;
  logic [3:0]    pending, pending_next;
  logic          status_given, status_given_next;

  always_comb begin
    logic [63:0] a;
    logic [31:0] v;
    logic        nf;
    logic [2:0]  last_idx;
    logic [7:0]  var_b;
    logic [7:0]  misc_b;
    logic        ramp, blight, water, bound;
    phase_next        = phase;
    bif_next          = bif;
    field_shift_next  = field_shift;
    version_next      = version;
    tiles_left_next   = tiles_left;
    map_width_next    = map_width;
    map_height_next   = map_height;
    width_bad_next    = width_bad;
    height_bad_next   = height_bad;
    corners_left_next = corners_left;
    bytes_seen_next   = bytes_seen;
    pending_next      = pending;
    status_given_next = status_given;
    cmd  = '0;
    push = 1'b0;
    a = field_shift;
    a[{bif, 3'b000} +: 8] = data_byte;
    v = a[31:0];
    nf = !version[31] && (version >= 32'd12);
    last_idx = (phase == PH_CORNERS) ? (nf ? 3'd7 : 3'd6) : 3'd3;
    if (nf) begin
      ramp = a[38]; blight = a[39]; water = a[40]; bound = a[41];
      var_b = a[55:48]; misc_b = a[63:56];
    end else begin
      ramp = a[36]; blight = a[37]; water = a[38]; bound = a[39];
      var_b = a[47:40]; misc_b = a[55:48];
    end
    if (accept) begin
      if (bytes_seen < 6'd32) bytes_seen_next = bytes_seen + 6'd1;
      unique case (phase)
        PH_SIG: begin
          if (data_byte != tmsp_pkg::sig_byte(bif[1:0])) begin
            bif_next     = 3'd0;
            pending_next = tmsp_pkg::ST_BADSIG;
            phase_next   = PH_DONE;
          end else if (bif >= 3'd3) begin
            bif_next   = 3'd0;
            phase_next = PH_VERSION;
          end else begin
            bif_next = bif + 3'd1;
          end
        end
        PH_TILESET: begin
          cmd.has_word   = 1'b1;
          cmd.word_kind  = tmsp_pkg::KIND_HEADER;
          cmd.word_index = 4'd1;
          cmd.word_value = {24'd0, data_byte};
          phase_next     = PH_CUSTOM;
        end
        PH_DONE: begin
        end
        default: begin
          if (bif == last_idx) begin
            field_shift_next = '0;
            bif_next         = 3'd0;
            if (phase == PH_CORNERS) begin
              cmd.has_corner       = 1'b1;
              cmd.raw_height       = a[15:0];
              cmd.water_raw        = a[29:16];
              cmd.ground_texture   = nf ? a[37:32] : {2'b00, a[35:32]};
              cmd.corner_flags     = {a[30], bound, water, blight, ramp};
              cmd.ground_variation = var_b[4:0];
              cmd.cliff_variation  = var_b[7:5];
              cmd.cliff_texture    = misc_b[7:4];
              cmd.layer_height     = misc_b[3:0];
              corners_left_next    = corners_left - CW'(1);
              if (corners_left == CW'(1)) begin
                cmd.corner_final  = 1'b1;
                status_given_next = 1'b1;
                phase_next        = PH_DONE;
              end
            end else begin
              cmd.has_word   = 1'b1;
              cmd.word_kind  = tmsp_pkg::KIND_HEADER;
              cmd.word_value = v;
              unique case (phase)
                PH_VERSION: begin
                  version_next   = v;
                  cmd.word_index = 4'd0;
                  phase_next     = PH_TILESET;
                end
                PH_CUSTOM: begin
                  cmd.word_index = 4'd2;
                  phase_next     = PH_GCOUNT;
                end
                PH_GCOUNT, PH_CCOUNT: begin
                  cmd.word_index = (phase == PH_GCOUNT) ? 4'd3 : 4'd4;
                  if (v[31] || v > 32'(MAX_TILE_COUNT)) begin
                    pending_next = (phase == PH_GCOUNT) ? tmsp_pkg::ST_BADGCNT
                                                        : tmsp_pkg::ST_BADCCNT;
                    phase_next   = PH_DONE;
                  end else begin
                    tiles_left_next = v[TW-1:0];
                    if (phase == PH_GCOUNT) phase_next = (v != 32'd0) ? PH_GTILES : PH_CCOUNT;
                    else phase_next = (v != 32'd0) ? PH_CTILES : PH_WIDTH;
                  end
                end
                PH_GTILES, PH_CTILES: begin
                  cmd.word_kind   = (phase == PH_GTILES) ? tmsp_pkg::KIND_GTILE
                                                         : tmsp_pkg::KIND_CTILE;
                  tiles_left_next = tiles_left - TW'(1);
                  if (tiles_left == TW'(1))
                    phase_next = (phase == PH_GTILES) ? PH_CCOUNT : PH_WIDTH;
                end
                PH_WIDTH: begin
                  cmd.word_index = 4'd5;
                  map_width_next = v[SW-1:0];
                  width_bad_next = (v == 32'd0) || v[31] || (v > 32'(MAX_MAP_SIDE));
                  phase_next     = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                  cmd.word_index  = 4'd6;
                  map_height_next = v[SW-1:0];
                  height_bad_next = (v == 32'd0) || v[31] || (v > 32'(MAX_MAP_SIDE));
                  phase_next      = PH_OFFX;
                end
                PH_OFFX: begin
                  cmd.word_index = 4'd7;
                  phase_next     = PH_OFFY;
                end
                default: begin
                  cmd.word_index = 4'd8;
                  if (width_bad || height_bad) begin
                    pending_next = tmsp_pkg::ST_BADSIZE;
                    phase_next   = PH_DONE;
                  end else begin
                    corners_left_next = CW'(map_width) * CW'(map_height);
                    phase_next        = PH_CORNERS;
                  end
                end
              endcase
            end
          end else begin
            field_shift_next = a;
            bif_next         = bif + 3'd1;
          end
        end
      endcase
      if (end_of_file) begin
        if (!status_given_next) begin
          cmd.has_status = 1'b1;
          if (bytes_seen_next < 6'd32) cmd.status_code = tmsp_pkg::ST_SHORT;
          else if (pending_next != tmsp_pkg::ST_OK) cmd.status_code = pending_next;
          else if (phase_next == PH_GTILES || phase_next == PH_CTILES)
            cmd.status_code = tmsp_pkg::ST_TRTILE;
          else if (phase_next == PH_CORNERS) cmd.status_code = tmsp_pkg::ST_TRCORNER;
          else cmd.status_code = tmsp_pkg::ST_TRHDR;
        end
        phase_next        = PH_SIG;
        bif_next          = 3'd0;
        field_shift_next  = '0;
        version_next      = '0;
        tiles_left_next   = '0;
        map_width_next    = '0;
        map_height_next   = '0;
        width_bad_next    = 1'b0;
        height_bad_next   = 1'b0;
        corners_left_next = '0;
        bytes_seen_next   = '0;
        pending_next      = tmsp_pkg::ST_OK;
        status_given_next = 1'b0;
      end
      push = cmd.has_word || cmd.has_corner || cmd.has_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      bif          <= 3'd0;
      field_shift  <= '0;
      version      <= '0;
      tiles_left   <= '0;
      map_width    <= '0;
      map_height   <= '0;
      width_bad    <= 1'b0;
      height_bad   <= 1'b0;
      corners_left <= '0;
      bytes_seen   <= '0;
      pending      <= tmsp_pkg::ST_OK;
      status_given <= 1'b0;
    end else begin
      phase        <= phase_next;
      bif          <= bif_next;
      field_shift  <= field_shift_next;
      version      <= version_next;
      tiles_left   <= tiles_left_next;
      map_width    <= map_width_next;
      map_height   <= map_height_next;
      width_bad    <= width_bad_next;
      height_bad   <= height_bad_next;
      corners_left <= corners_left_next;
      bytes_seen   <= bytes_seen_next;
      pending      <= pending_next;
      status_given <= status_given_next;
    end
  end

endmodule

// File: sv/tmsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_queue
// short command queue between the parser front and the result back end
// ----------------------------------------------------------------------------
module tmsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tmsp_pkg::cmd_t push_cmd,
  output logic           not_full,
  input  logic           pop,
  output logic           head_valid,
  output tmsp_pkg::cmd_t head_cmd
);

  tmsp_pkg::cmd_t               mem [tmsp_pkg::QDEPTH];
  logic [tmsp_pkg::QPW-1:0]     wr_ptr, rd_ptr;
  logic [tmsp_pkg::QCW-1:0]     count;

  assign not_full   = count != tmsp_pkg::QCW'(tmsp_pkg::QDEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + tmsp_pkg::QPW'(1);
      if (pop) rd_ptr <= rd_ptr + tmsp_pkg::QPW'(1);
      if (push && !pop) count <= count + tmsp_pkg::QCW'(1);
      else if (pop && !push) count <= count - tmsp_pkg::QCW'(1);
    end
  end

endmodule

// File: sv/tmsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsp_back
// expands commands into result transactions and keeps the corner statistics
// ----------------------------------------------------------------------------
module tmsp_back #(
  parameter int MAX_MAP_SIDE = tmsp_pkg::MAX_MAP_SIDE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tmsp_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [95:0]    m_tdata,
  output logic [2:0]     m_tuser,
  output logic           m_tlast
);

  localparam int CW = 2 * $clog2(MAX_MAP_SIDE + 1);

  localparam logic [1:0] SQ_MAIN   = 2'd0;
  localparam logic [1:0] SQ_STATS  = 2'd1;
  localparam logic [1:0] SQ_OK     = 2'd2;
  localparam logic [1:0] SQ_STATUS = 2'd3;

  logic          started;
  logic [1:0]    sq;
  logic [3:0]    idx;
  logic [1:0]    cur_sq, nxt_sq;
  logic          done;
  logic          fire;

  logic [15:0]   min_h, max_h;
  logic [13:0]   min_w, max_w;
  logic [CW-1:0] cnt [5];

  logic [2:0]  kind;
  logic [15:0] o_rh;
  logic [13:0] o_wr;
  logic [5:0]  o_gt;
  logic [4:0]  o_cf, o_gv;
  logic [2:0]  o_cv;
  logic [3:0]  o_ct, o_lh, o_ii;
  logic [31:0] o_iv;

  assign cur_sq = started ? sq
                : ((head_cmd.has_word || head_cmd.has_corner) ? SQ_MAIN : SQ_STATUS);
  assign fire   = head_valid && m_tready;

  always_comb begin
    nxt_sq = SQ_STATUS;
    done   = 1'b1;
    unique case (cur_sq)
      SQ_MAIN: begin
        if (head_cmd.has_corner && head_cmd.corner_final) begin
          nxt_sq = SQ_STATS; done = 1'b0;
        end else if (head_cmd.has_status) begin
          nxt_sq = SQ_STATUS; done = 1'b0;
        end
      end
      SQ_STATS: begin
        if (idx == tmsp_pkg::LAST_STAT) nxt_sq = SQ_OK;
        else nxt_sq = SQ_STATS;
        done = 1'b0;
      end
      SQ_OK:     done = 1'b1;
      default:   done = 1'b1;
    endcase
  end

  always_comb begin
    kind = tmsp_pkg::KIND_STATUS;
    o_rh = '0; o_wr = '0; o_gt = '0; o_cf = '0; o_gv = '0;
    o_cv = '0; o_ct = '0; o_lh = '0; o_ii = '0; o_iv = '0;
    unique case (cur_sq)
      SQ_MAIN: begin
        if (head_cmd.has_corner) begin
          kind = tmsp_pkg::KIND_CORNER;
          o_rh = head_cmd.raw_height;
          o_wr = head_cmd.water_raw;
          o_gt = head_cmd.ground_texture;
          o_cf = head_cmd.corner_flags;
          o_gv = head_cmd.ground_variation;
          o_cv = head_cmd.cliff_variation;
          o_ct = head_cmd.cliff_texture;
          o_lh = head_cmd.layer_height;
        end else begin
          kind = head_cmd.word_kind;
          o_ii = head_cmd.word_index;
          o_iv = head_cmd.word_value;
        end
      end
      SQ_STATS: begin
        kind = tmsp_pkg::KIND_STAT;
        o_ii = idx;
        case (idx)
          4'd0:    o_iv = {16'd0, min_h};
          4'd1:    o_iv = {16'd0, max_h};
          4'd2:    o_iv = {18'd0, min_w};
          4'd3:    o_iv = {18'd0, max_w};
          4'd4:    o_iv = 32'(cnt[0]);
          4'd5:    o_iv = 32'(cnt[1]);
          4'd6:    o_iv = 32'(cnt[2]);
          4'd7:    o_iv = 32'(cnt[3]);
          default: o_iv = 32'(cnt[4]);
        endcase
      end
      SQ_OK:   o_iv = {28'd0, tmsp_pkg::ST_OK};
      default: o_iv = {28'd0, head_cmd.status_code};
    endcase
  end

  assign pop      = fire && done;
  assign m_tvalid = head_valid;
  assign m_tuser  = kind;
  assign m_tlast  = done;
  assign m_tdata  = {3'd0, o_iv, o_ii, o_lh, o_ct, o_cv, o_gv, o_cf, o_gt, o_wr, o_rh};

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      sq      <= SQ_MAIN;
      idx     <= '0;
    end else if (fire) begin
      if (done) begin
        started <= 1'b0;
        idx     <= '0;
      end else begin
        started <= 1'b1;
        sq      <= nxt_sq;
        if (cur_sq == SQ_STATS) idx <= idx + 4'd1;
        else idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && (cur_sq == SQ_OK || cur_sq == SQ_STATUS))) begin
      min_h <= 16'hFFFF;
      max_h <= '0;
      min_w <= 14'h3FFF;
      max_w <= '0;
      for (int k = 0; k < 5; k++) cnt[k] <= '0;
    end else if (fire && cur_sq == SQ_MAIN && head_cmd.has_corner) begin
      if (head_cmd.raw_height < min_h) min_h <= head_cmd.raw_height;
      if (head_cmd.raw_height > max_h) max_h <= head_cmd.raw_height;
      if (head_cmd.water_raw < min_w) min_w <= head_cmd.water_raw;
      if (head_cmd.water_raw > max_w) max_w <= head_cmd.water_raw;
      cnt[0] <= cnt[0] + CW'(head_cmd.corner_flags[2]);
      cnt[1] <= cnt[1] + CW'(head_cmd.corner_flags[3]);
      cnt[2] <= cnt[2] + CW'(head_cmd.corner_flags[0]);
      cnt[3] <= cnt[3] + CW'(head_cmd.corner_flags[1]);
      cnt[4] <= cnt[4] + CW'(head_cmd.corner_flags[4]);
    end
  end

endmodule

// File: sv/terrain_map_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terrain_map_stream_parser
// parses a terrain file byte stream into header, tile, corner and statistic
// results, closing each file with a status transaction
// ----------------------------------------------------------------------------
// input: one file byte per transaction on s_tdata, s_tlast on the final byte
// output: one result per transaction, m_tuser the kind, m_tlast on the final
//   result caused by one input byte
// one input byte is taken per cycle while the four-entry command queue has
// room; the front parses in the cycle of acceptance, the back end sends one
// result per cycle while m_tready is high, so a result leaves at the earliest
// in the cycle after its byte; a byte ending the last corner record causes
// eleven results; the queue absorbs short bursts of such bytes
// a stalled receiver fills the queue, after which s_tready drops
// reset empties the queue and returns the parser to the signature phase;
// the parser also returns there after every byte marked with s_tlast
// ----------------------------------------------------------------------------
module terrain_map_stream_parser #(
  parameter int MAX_TILE_COUNT = tmsp_pkg::MAX_TILE_COUNT_DEF,
  parameter int MAX_MAP_SIDE   = tmsp_pkg::MAX_MAP_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  // raw_height, water_raw, ground_texture, corner_flags, ground_variation,
  // cliff_variation, cliff_texture, layer_height, info_index, info_value
  output logic [95:0] m_tdata,
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  logic           push, pop, not_full, head_valid;
  tmsp_pkg::cmd_t push_cmd, head_cmd;

  assign s_tready = not_full;

  tmsp_front #(
    .MAX_TILE_COUNT(MAX_TILE_COUNT),
    .MAX_MAP_SIDE  (MAX_MAP_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_tvalid && not_full),
    .data_byte  (s_tdata),
    .end_of_file(s_tlast),
    .push       (push),
    .cmd        (push_cmd)
  );

  tmsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (not_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  tmsp_back #(
    .MAX_MAP_SIDE(MAX_MAP_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
